/* src/bmtr_pkg.sv */
// Package for the bitmap text renderer: command codes, FSM states, payload types, defaults.
`default_nettype none

package bmtr_pkg;

  // Default geometry of the font and the glyph store.
  localparam int unsigned GlyphSizeDef  = 8;
  localparam int unsigned CellPitchDef  = 9;
  localparam int unsigned FirstCodeDef  = 32;
  localparam int unsigned GlyphCountDef = 96;

  // Character code that moves the cursor to the next text row.
  localparam logic [7:0] NewlineCode = 8'd10;
  // Both cursor coordinates saturate at this value.
  localparam logic [7:0] CursorMax   = 8'd255;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_RENDER = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [2:0]  glyph_row;
    logic [7:0]  row_bits;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [31:0] color;
  } in_t;

  typedef struct packed {
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [31:0] pixel_color;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

/* src/bitmap_text_renderer.sv */
// Top level of the bitmap text renderer: glyph store, fetch and scan sequencer, pixel output.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ---------------------------
// in        input      in_valid_i / in_stall_o   in_i  (command, code, row...)
// out       output     out_valid_o / out_stall_i out_o (pixel_x, pixel_y, ...)
//
// Load, begin, newline, unused-command and out-of-range-code transactions finish in the cycle they are accepted in.
// A render of a stored glyph first fetches its rows from the glyph store (one synchronous
// read port, one row per cycle), then scans the glyph bits up to the last lit bit and
// returns to idle; a new input transaction is taken only once it is back in idle.
// Stalls on the output hold the scan; the output register lets the next input transaction be
// taken while the final pixel still waits. Reset clears all control state and the latched
// origin, colour and cursor; the glyph store has no reset and reads undefined until loaded.
module bitmap_text_renderer #(
  parameter int unsigned GLYPH_SIZE  = bmtr_pkg::GlyphSizeDef,
  parameter int unsigned CELL_PITCH  = bmtr_pkg::CellPitchDef,
  parameter int unsigned FIRST_CODE  = bmtr_pkg::FirstCodeDef,
  parameter int unsigned GLYPH_COUNT = bmtr_pkg::GlyphCountDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bmtr_pkg::in_t in_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bmtr_pkg::out_t     out_o
);
  import bmtr_pkg::*;

  // Geometry derived from the parameters.
  localparam int unsigned Depth = GLYPH_COUNT * GLYPH_SIZE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned NCols = (GLYPH_SIZE < 8) ? GLYPH_SIZE : 8;
  localparam int unsigned VW    = NCols * GLYPH_SIZE;
  localparam int unsigned IW    = $clog2(VW);
  localparam int unsigned RW    = $clog2(GLYPH_SIZE);
  localparam int unsigned CW    = $clog2(NCols);

  // Glyph store: one 8-bit row per entry, one write and one registered read per cycle.
  logic [7:0] glyph_mem [Depth];

  state_e          state_q, state_d;
  logic [RW-1:0]   fetch_row_q, fetch_row_d;
  logic            issue_done_q, issue_done_d;
  logic            rd_valid_q;
  logic [RW-1:0]   rd_row_q;
  logic [7:0]      rd_data_q;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;

  // The lit bits of the current glyph, laid out in scan order: column-major.
  logic [VW-1:0]   vec_q, vec_d;
  logic [VW-1:0]   vec_clr;
  logic [CW-1:0]   scan_col_q, scan_col_d;
  logic [RW-1:0]   scan_row_q, scan_row_d;
  logic [IW-1:0]   scan_idx_q, scan_idx_d;

  logic [12:0]     base_x_q, base_x_d;
  logic [12:0]     base_y_q, base_y_d;
  logic [AW-1:0]   slot_base_q, slot_base_d;
  logic [11:0]     origin_x_q, origin_x_d;
  logic [11:0]     origin_y_q, origin_y_d;
  logic [31:0]     text_color_q, text_color_d;
  logic [7:0]      cursor_col_q, cursor_col_d;
  logic [7:0]      cursor_row_q, cursor_row_d;

  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic            accept;
  logic            out_free;
  logic            emit;
  logic [8:0]      rel_code;
  logic            code_in_range;
  logic            row_in_range;
  logic [AW-1:0]   slot_base;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Character code relative to the first stored glyph, and whether a glyph exists for it.
  assign rel_code      = {1'b0, in_i.char_code} - 9'(FIRST_CODE);
  assign code_in_range = (in_i.char_code >= 8'(FIRST_CODE)) && (rel_code < 9'(GLYPH_COUNT));
  assign row_in_range  = {29'd0, in_i.glyph_row} < 32'(GLYPH_SIZE);
  assign slot_base     = AW'(rel_code) * AW'(GLYPH_SIZE);

  // A load writes in its own accept cycle, so a render that follows directly already reads
  // the new row: its first read is issued in the cycle after it is accepted.
  assign wr_en   = accept && (in_i.command == CMD_LOAD) && code_in_range && row_in_range;
  assign wr_addr = slot_base + AW'(in_i.glyph_row);
  assign rd_addr = slot_base_q + AW'(fetch_row_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      glyph_mem[wr_addr] <= in_i.row_bits;
    end
    if (rd_en) begin
      rd_data_q <= glyph_mem[rd_addr];
    end
  end

  // The scan clears each bit as it passes it; the pixel is the last one when nothing is left.
  assign vec_clr = vec_q & ~(VW'(1) << scan_idx_q);

  always_comb begin
    state_d      = state_q;
    fetch_row_d  = fetch_row_q;
    issue_done_d = issue_done_q;
    rd_en        = 1'b0;
    vec_d        = vec_q;
    scan_col_d   = scan_col_q;
    scan_row_d   = scan_row_q;
    scan_idx_d   = scan_idx_q;
    base_x_d     = base_x_q;
    base_y_d     = base_y_q;
    slot_base_d  = slot_base_q;
    origin_x_d   = origin_x_q;
    origin_y_d   = origin_y_q;
    text_color_d = text_color_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    emit         = 1'b0;
    in_stall_o   = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.command)
            CMD_BEGIN: begin
              origin_x_d   = in_i.origin_x;
              origin_y_d   = in_i.origin_y;
              text_color_d = in_i.color;
              cursor_col_d = '0;
              cursor_row_d = '0;
            end
            CMD_RENDER: begin
              if (in_i.char_code == NewlineCode) begin
                cursor_col_d = '0;
                cursor_row_d = (cursor_row_q == CursorMax) ? CursorMax : cursor_row_q + 8'd1;
              end else begin
                cursor_col_d = (cursor_col_q == CursorMax) ? CursorMax : cursor_col_q + 8'd1;
                if (code_in_range) begin
                  // The cell origin uses the cursor before this character advances it.
                  base_x_d     = 13'(origin_x_q) + 13'(cursor_col_q) * 13'(CELL_PITCH);
                  base_y_d     = 13'(origin_y_q) + 13'(cursor_row_q) * 13'(CELL_PITCH);
                  slot_base_d  = slot_base;
                  fetch_row_d  = '0;
                  issue_done_d = 1'b0;
                  vec_d        = '0;
                  scan_col_d   = '0;
                  scan_row_d   = '0;
                  scan_idx_d   = '0;
                  state_d      = ST_FETCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        // Issue one row read per cycle; each row lands in the next cycle.
        if (!issue_done_q) begin
          rd_en = 1'b1;
          if (32'(fetch_row_q) == GLYPH_SIZE - 1) begin
            issue_done_d = 1'b1;
          end else begin
            fetch_row_d = fetch_row_q + RW'(1);
          end
        end
        if (rd_valid_q) begin
          for (int c = 0; c < NCols; c++) begin
            for (int r = 0; r < GLYPH_SIZE; r++) begin
              if (32'(rd_row_q) == r) begin
                vec_d[c * GLYPH_SIZE + r] = rd_data_q[c];
              end
            end
          end
          if (32'(rd_row_q) == GLYPH_SIZE - 1) begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (vec_q == '0) begin
          state_d = ST_IDLE;
        end else if (!vec_q[scan_idx_q] || out_free) begin
          emit       = vec_q[scan_idx_q];
          vec_d      = vec_clr;
          scan_idx_d = scan_idx_q + IW'(1);
          if (32'(scan_row_q) == GLYPH_SIZE - 1) begin
            scan_row_d = '0;
            scan_col_d = scan_col_q + CW'(1);
          end else begin
            scan_row_d = scan_row_q + RW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded on a lit bit, emptied when the sink takes the pixel.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.pixel_x     = base_x_q + 13'(scan_col_q);
      out_d.pixel_y     = base_y_q + 13'(scan_row_q);
      out_d.pixel_color = text_color_q;
      out_d.last        = (vec_clr == '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fetch_row_q  <= '0;
      issue_done_q <= 1'b0;
      rd_valid_q   <= 1'b0;
      rd_row_q     <= '0;
      vec_q        <= '0;
      scan_col_q   <= '0;
      scan_row_q   <= '0;
      scan_idx_q   <= '0;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      text_color_q <= '0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fetch_row_q  <= fetch_row_d;
      issue_done_q <= issue_done_d;
      rd_valid_q   <= rd_en;
      rd_row_q     <= fetch_row_q;
      vec_q        <= vec_d;
      scan_col_q   <= scan_col_d;
      scan_row_q   <= scan_row_d;
      scan_idx_q   <= scan_idx_d;
      origin_x_q   <= origin_x_d;
      origin_y_q   <= origin_y_d;
      text_color_q <= text_color_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_x_q    <= base_x_d;
    base_y_q    <= base_y_d;
    slot_base_q <= slot_base_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A scan with no lit bits left always returns to idle in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && vec_q == '0) |=> (state_q == ST_IDLE))
    else $error("scan did not finish with an empty glyph");

  // The colour cannot change while a character is being fetched or scanned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(text_color_q))
    else $error("text colour changed during a render");

  // A saturated column cursor only stays at its maximum or is cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_col_q == CursorMax) |=> (cursor_col_q == CursorMax || cursor_col_q == '0))
    else $error("column cursor wrapped past its maximum");

endmodule

`default_nettype wire

/* bench/bitmap_text_renderer_tb.sv */
// Self-checking testbench for the bitmap text renderer: queued commands, pixel scoreboard.
module bitmap_text_renderer_tb;
  import bmtr_pkg::*;

  // The block runs with its default geometry, so the pixel predictor uses the same numbers.
  localparam int unsigned GlyphSize  = GlyphSizeDef;
  localparam int unsigned CellPitch  = CellPitchDef;
  localparam int unsigned FirstCode  = FirstCodeDef;
  localparam int unsigned GlyphCount = GlyphCountDef;
  localparam int unsigned StoreDepth = GlyphSize * GlyphCount;
  localparam int unsigned LastCode   = FirstCode + GlyphCount - 1;

  // The command field can carry a fourth code that the block must ignore.
  localparam logic [1:0] CmdUnused = 2'd3;

  // Least number of random transactions that follow the directed ones.
  localparam int unsigned RandomItems = 152;
  // Cycles to keep watching after the last expected pixel, long enough for a whole render
  // to finish, so this catches any stray pixel.
  localparam int unsigned TailCycles = 100;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_q  = 1'b0;
  in_t  in_item_q   = '0;
  logic out_stall_q = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_pixel;

  // Commands still waiting to be presented to the block, filled before reset is released.
  in_t         pending_items[$];
  int unsigned total_items = 0;
  int unsigned taken_count = 0;
  int unsigned error_count = 0;
  // High when the input transaction shown during the last cycle was accepted.
  logic        item_taken  = 1'b0;

  // Pixels that the accepted commands must still produce, oldest first.
  out_t        due_pixels[$];
  out_t        want_pixel;

  // Shadow copy of the block's state, updated at every accepted input transaction.
  logic [7:0]  font_rows [StoreDepth];
  logic [11:0] org_x   = '0;
  logic [11:0] org_y   = '0;
  logic [31:0] ink     = '0;
  logic [7:0]  cur_col = '0;
  logic [7:0]  cur_row = '0;

  // Stimulus-side bookkeeping: which glyph rows have been loaded, and which glyphs are
  // complete. Only complete glyphs are ever rendered, so no unwritten row is ever read.
  bit          row_loaded [StoreDepth];
  bit          glyph_complete [GlyphCount];
  logic [7:0]  ready_codes[$];

  bitmap_text_renderer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_stall_o (in_stall),
    .in_i       (in_item_q),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall_q),
    .out_o      (out_pixel)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Queue appends, one per queue.
  task automatic add_pending(input in_t it);
    pending_items = {pending_items, it};
  endtask

  task automatic add_due(input out_t px);
    due_pixels = {due_pixels, px};
  endtask

  task automatic add_ready(input logic [7:0] code);
    ready_codes = {ready_codes, code};
  endtask

  // The run goes through three idling regimes, chosen by how far the input has progressed:
  // first a busy sender facing a slow receiver, then the reverse, then no idling at all.
  function automatic int unsigned idle_stage();
    return (total_items == 0) ? 2 : (taken_count * 3) / total_items;
  endfunction

  // A transaction with every field random. Fields that the command does not use keep
  // their random content, so the block is shown to ignore them.
  function automatic in_t scrambled_item(logic [1:0] cmd);
    in_t it;
    it.command   = cmd;
    it.char_code = 8'($urandom);
    it.glyph_row = 3'($urandom);
    it.row_bits  = 8'($urandom);
    it.origin_x  = 12'($urandom);
    it.origin_y  = 12'($urandom);
    it.color     = $urandom;
    return it;
  endfunction

  // Coordinates often sit at the ends of their range.
  function automatic logic [11:0] pick_coord();
    case ($urandom_range(3))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  // A code that has no glyph and is not a newline: drawn blank, but the cursor moves.
  function automatic logic [7:0] blank_code();
    logic [7:0] code;
    code = ($urandom_range(1) == 0) ? 8'($urandom_range(FirstCode - 1))
                                    : 8'($urandom_range(255, LastCode + 1));
    if (code == NewlineCode) begin
      code = 8'd0;
    end
    return code;
  endfunction

  function automatic logic [7:0] ready_code();
    return ready_codes[$urandom_range(ready_codes.size() - 1)];
  endfunction

  task automatic queue_load(input logic [7:0] code, input logic [2:0] row,
                            input logic [7:0] bits);
    in_t         it;
    int unsigned slot;
    int unsigned r;
    bit          whole;
    it           = scrambled_item(CMD_LOAD);
    it.char_code = code;
    it.glyph_row = row;
    it.row_bits  = bits;
    add_pending(it);
    if (code >= FirstCode && code <= LastCode) begin
      slot = code - FirstCode;
      row_loaded[slot * GlyphSize + row] = 1'b1;
      whole = 1'b1;
      for (r = 0; r < GlyphSize; r++) begin
        whole &= row_loaded[slot * GlyphSize + r];
      end
      if (whole && !glyph_complete[slot]) begin
        glyph_complete[slot] = 1'b1;
        add_ready(code);
      end
    end
  endtask

  task automatic queue_begin(input logic [11:0] x, input logic [11:0] y,
                             input logic [31:0] color);
    in_t it;
    it          = scrambled_item(CMD_BEGIN);
    it.origin_x = x;
    it.origin_y = y;
    it.color    = color;
    add_pending(it);
  endtask

  task automatic queue_render(input logic [7:0] code);
    in_t it;
    it           = scrambled_item(CMD_RENDER);
    it.char_code = code;
    add_pending(it);
  endtask

  // Pixel predictor. It updates the shadow state for one accepted command and appends the
  // pixels that command must produce: columns in the outer loop, glyph rows within each
  // column, with the last flag on the final lit bit only.
  task automatic apply_command(input in_t it);
    out_t        held;
    bit          have_held;
    int unsigned slot;
    int unsigned col;
    int unsigned row;
    logic [12:0] base_x;
    logic [12:0] base_y;
    held      = '0;
    have_held = 1'b0;
    case (it.command)
      CMD_LOAD: begin
        // Loads outside the glyph range are dropped.
        if (it.char_code >= FirstCode && it.char_code <= LastCode &&
            it.glyph_row < GlyphSize) begin
          font_rows[(it.char_code - FirstCode) * GlyphSize + it.glyph_row] = it.row_bits;
        end
      end
      CMD_BEGIN: begin
        org_x   = it.origin_x;
        org_y   = it.origin_y;
        ink     = it.color;
        cur_col = '0;
        cur_row = '0;
      end
      CMD_RENDER: begin
        if (it.char_code == NewlineCode) begin
          // A newline only moves the cursor; the row saturates.
          cur_col = '0;
          if (cur_row != CursorMax) begin
            cur_row = cur_row + 8'd1;
          end
        end else begin
          if (it.char_code >= FirstCode && it.char_code <= LastCode) begin
            slot   = it.char_code - FirstCode;
            base_x = 13'(org_x + CellPitch * cur_col);
            base_y = 13'(org_y + CellPitch * cur_row);
            for (col = 0; col < GlyphSize && col < 8; col++) begin
              for (row = 0; row < GlyphSize; row++) begin
                if (font_rows[slot * GlyphSize + row][col]) begin
                  // The previous pixel is not the final one, so it can go out now.
                  if (have_held) begin
                    add_due(held);
                  end
                  held.pixel_x     = base_x + 13'(col);
                  held.pixel_y     = base_y + 13'(row);
                  held.pixel_color = ink;
                  held.last        = 1'b0;
                  have_held        = 1'b1;
                end
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              add_due(held);
            end
          end
          // Every non-newline character advances the column, blank or not, up to saturation.
          if (cur_col != CursorMax) begin
            cur_col = cur_col + 8'd1;
          end
        end
      end
      default: begin
        // The unused command code leaves everything as it is.
      end
    endcase
  endtask

  // Monitor. At each rising edge an accepted input transaction feeds the predictor, and an
  // accepted output transaction is checked against the oldest expected pixel.
  always @(posedge clk_i) begin
    item_taken <= rst_ni && in_valid_q && !in_stall;
    if (rst_ni && in_valid_q && !in_stall) begin
      apply_command(in_item_q);
      taken_count = taken_count + 1;
    end
    if (rst_ni && out_valid && !out_stall_q) begin
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d color=%h last=%b",
                 $time, out_pixel.pixel_x, out_pixel.pixel_y, out_pixel.pixel_color,
                 out_pixel.last);
        error_count = error_count + 1;
      end else begin
        want_pixel = due_pixels.pop_front();
        if (out_pixel.pixel_x !== want_pixel.pixel_x ||
            out_pixel.pixel_y !== want_pixel.pixel_y ||
            out_pixel.pixel_color !== want_pixel.pixel_color ||
            out_pixel.last !== want_pixel.last) begin
          $display("%0t: mismatch, exp x=%0d y=%0d c=%h l=%b, got x=%0d y=%0d c=%h l=%b",
                   $time, want_pixel.pixel_x, want_pixel.pixel_y, want_pixel.pixel_color,
                   want_pixel.last, out_pixel.pixel_x, out_pixel.pixel_y,
                   out_pixel.pixel_color, out_pixel.last);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Driver. At each falling edge a new command or an idle cycle is shown once the previous
  // one was taken or none was shown; a stalled command is held unchanged. The receiver stall
  // is redrawn every cycle according to the current idling regime.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_q || item_taken) begin
        if (pending_items.size() != 0 &&
            $urandom_range(99) >= ((idle_stage() == 0) ? 7 : (idle_stage() == 1) ? 79 : 0)) begin
          in_item_q  <= pending_items.pop_front();
          in_valid_q <= 1'b1;
        end else begin
          in_valid_q <= 1'b0;
        end
      end
      out_stall_q <= ($urandom_range(99) <
                      ((idle_stage() == 0) ? 79 : (idle_stage() == 1) ? 7 : 0));
    end
  end

  initial begin
    int unsigned directed_count;
    int unsigned pick;
    int unsigned style;
    int unsigned r;
    int unsigned n;
    logic [7:0]  code;
    logic [7:0]  bits;

    // Directed part. The first glyph is fully lit (the largest render, 64 pixels) and the
    // last glyph is loaded blank, so it emits nothing and never flags a last pixel.
    for (r = 0; r < GlyphSize; r++) begin
      queue_load(8'(FirstCode), 3'(r), 8'hFF);
    end
    for (r = 0; r < GlyphSize; r++) begin
      queue_load(8'(LastCode), 3'(r), 8'h00);
    end
    // Loads just below and just above the glyph range must be dropped.
    queue_load(8'(FirstCode - 1), 3'd7, 8'hFF);
    queue_load(8'(LastCode + 1), 3'd0, 8'hFF);
    // Largest origin and colour; full, blank, glyphless, newline, unused and full again.
    queue_begin(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    queue_render(8'(FirstCode));
    queue_render(8'(LastCode));
    queue_render(8'h00);
    queue_render(8'hFF);
    queue_render(NewlineCode);
    add_pending(scrambled_item(CmdUnused));
    queue_render(8'(FirstCode));
    // Smallest origin and colour.
    queue_begin(12'h000, 12'h000, 32'h0000_0000);
    queue_render(8'(FirstCode));
    directed_count = pending_items.size();

    // Random part: mostly glyph definitions and text strings with random content, and some
    // stray transactions.
    while (pending_items.size() < directed_count + RandomItems) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        // Define a whole glyph; sparse styles keep the pixel count moderate.
        code  = 8'($urandom_range(LastCode, FirstCode));
        style = $urandom_range(3);
        for (r = 0; r < GlyphSize; r++) begin
          case (style)
            0:       bits = 8'($urandom) & 8'($urandom);
            1:       bits = 8'(1 << $urandom_range(7));
            2:       bits = ($urandom_range(3) == 0) ? 8'hFF : 8'h00;
            default: bits = 8'($urandom);
          endcase
          queue_load(code, 3'(r), bits);
        end
      end else if (pick < 85) begin
        // A string: a begin, then characters, newlines, blank codes and unused commands.
        queue_begin(pick_coord(), pick_coord(), $urandom);
        n = $urandom_range(12, 1);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 75) begin
            queue_render(ready_code());
          end else if (pick < 85) begin
            queue_render(NewlineCode);
          end else if (pick < 95) begin
            queue_render(blank_code());
          end else begin
            add_pending(scrambled_item(CmdUnused));
          end
        end
      end else begin
        // Stray transactions: a load anywhere, a character without a glyph, the unused code.
        case ($urandom_range(2))
          0:       queue_load(8'($urandom), 3'($urandom), 8'($urandom));
          1:       queue_render(blank_code());
          default: add_pending(scrambled_item(CmdUnused));
        endcase
      end
    end
    total_items = pending_items.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every command has been taken and every predicted pixel has arrived, then
    // watch a little longer for pixels that should not be there.
    while (taken_count < total_items || due_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every render fully lit.
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/bmtr_pkg.sv
src/bitmap_text_renderer.sv
bench/bitmap_text_renderer_tb.sv
